// File: sv/gfr_pkg.sv
// ----------------------------------------------------------------------------
// gfr_pkg
// Shared constants and codes of the GF(2) four Russians row multiplier.
// ----------------------------------------------------------------------------
package gfr_pkg;

	localparam int CHUNK_BITS_DEF = 7;
	localparam int WORD_BITS_DEF  = 64;

	localparam int PORT_W = 64;
	localparam int ADDR_W = 11;

	typedef enum logic [1:0] {
		FUNC_WRITE  = 2'd0,
		FUNC_ASSIGN = 2'd1,
		FUNC_ACC    = 2'd2
	} func_t;

endpackage

// File: sv/gfr_bank.sv
// ----------------------------------------------------------------------------
// gfr_bank
// One combination table: a single-port write, single-port read memory with
// registered read data.
// ----------------------------------------------------------------------------
module gfr_bank #(
	parameter int INDEX_BITS = 7,
	parameter int DATA_W     = 64
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [INDEX_BITS-1:0] waddr,
	input  logic [DATA_W-1:0]     wdata,
	input  logic                  re,
	input  logic [INDEX_BITS-1:0] raddr,
	output logic [DATA_W-1:0]     rdata
);

	localparam int DEPTH = 1 << INDEX_BITS;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/gf2_four_russians_row_multiply.sv
// ----------------------------------------------------------------------------
// gf2_four_russians_row_multiply
// Multiplies rows of a GF(2) matrix by table lookup and XOR of the chunks.
// ----------------------------------------------------------------------------
// The block takes one item in every cycle and never raises busy. A multiply
// item passes through one register stage for the input, one for the table
// read, and one for the XOR of the table words, after which done marks its
// result on result_row and its last-row flag on row_last. Every
// chunk has a table memory of its own with its own read port, so all lookups
// of a row take place in the same cycle. A table write takes effect for
// every multiply accepted after it. A table word that has never been written
// reads as an unknown value. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module gf2_four_russians_row_multiply
	import gfr_pkg::*;
#(
	parameter int CHUNK_BITS = CHUNK_BITS_DEF,
	parameter int WORD_BITS  = WORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        func,
	input  logic [ADDR_W-1:0] table_addr,
	input  logic [PORT_W-1:0] table_word,
	input  logic [PORT_W-1:0] a_row,
	input  logic [PORT_W-1:0] c_row,
	input  logic              last_row,
	output logic              done,
	output logic [PORT_W-1:0] result_row,
	output logic              row_last
);

	localparam int NCHUNK    = (WORD_BITS - 8) / CHUNK_BITS;
	localparam int TOP_SHIFT = NCHUNK * CHUNK_BITS;
	localparam int TOP_BITS  = WORD_BITS - TOP_SHIFT;
	localparam int TOP_BASE  = NCHUNK * (1 << CHUNK_BITS);
	localparam int EXT_W     = ((TOP_BITS > ADDR_W) ? TOP_BITS : ADDR_W) + 1;

	logic                 mul_s1;
	logic                 acc_s1;
	logic                 last_s1;
	logic [WORD_BITS-1:0] a_s1;
	logic [WORD_BITS-1:0] c_s1;
	logic                 wr_s1;
	logic [ADDR_W-1:0]    waddr_s1;
	logic [WORD_BITS-1:0] wdata_s1;

	logic                 mul_s2;
	logic                 acc_s2;
	logic                 last_s2;
	logic [WORD_BITS-1:0] c_s2;

	logic                 done_s3;
	logic                 last_s3;
	logic [WORD_BITS-1:0] result_s3;

	logic [WORD_BITS-1:0] chunk_word_s2 [NCHUNK];
	logic [WORD_BITS-1:0] top_word_s2;
	logic [WORD_BITS-1:0] xor_sum;

	logic [EXT_W-1:0]     waddr_ext;
	logic [EXT_W-1:0]     top_offset;
	logic                 in_chunks;
	logic                 in_top;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s1 <= 1'b0;
			wr_s1  <= 1'b0;
		end else begin
			mul_s1 <= start && (func == FUNC_ASSIGN || func == FUNC_ACC);
			wr_s1  <= start && (func == FUNC_WRITE);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_s1   <= (func == FUNC_ACC);
			last_s1  <= last_row;
			a_s1     <= a_row[WORD_BITS-1:0];
			c_s1     <= c_row[WORD_BITS-1:0];
			waddr_s1 <= table_addr;
			wdata_s1 <= table_word[WORD_BITS-1:0];
		end
	end

	assign waddr_ext  = EXT_W'(waddr_s1);
	assign top_offset = waddr_ext - EXT_W'(TOP_BASE);
	assign in_chunks  = (waddr_ext < EXT_W'(TOP_BASE));
	assign in_top     = !in_chunks && ((top_offset >> TOP_BITS) == '0);

	for (genvar n = 0; n < NCHUNK; n++) begin : g_chunk
		logic we_n;

		assign we_n = wr_s1 && in_chunks &&
			((waddr_ext >> CHUNK_BITS) == EXT_W'(n));

		gfr_bank #(
			.INDEX_BITS (CHUNK_BITS),
			.DATA_W     (WORD_BITS)
		) u_bank (
			.clk   (clk),
			.we    (we_n),
			.waddr (waddr_s1[CHUNK_BITS-1:0]),
			.wdata (wdata_s1),
			.re    (mul_s1),
			.raddr (a_s1[n*CHUNK_BITS +: CHUNK_BITS]),
			.rdata (chunk_word_s2[n])
		);
	end

	gfr_bank #(
		.INDEX_BITS (TOP_BITS),
		.DATA_W     (WORD_BITS)
	) u_top_bank (
		.clk   (clk),
		.we    (wr_s1 && in_top),
		.waddr (top_offset[TOP_BITS-1:0]),
		.wdata (wdata_s1),
		.re    (mul_s1),
		.raddr (a_s1[TOP_SHIFT +: TOP_BITS]),
		.rdata (top_word_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s2 <= 1'b0;
		end else begin
			mul_s2 <= mul_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_s1) begin
			acc_s2  <= acc_s1;
			last_s2 <= last_s1;
			c_s2    <= c_s1;
		end
	end

	always_comb begin
		xor_sum = top_word_s2;
		for (int n = 0; n < NCHUNK; n++) begin
			xor_sum = xor_sum ^ chunk_word_s2[n];
		end
		if (acc_s2) begin
			xor_sum = xor_sum ^ c_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= mul_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_s2) begin
			result_s3 <= xor_sum;
			last_s3   <= last_s2;
		end
	end

	assign done       = done_s3;
	assign result_row = PORT_W'(result_s3);
	assign row_last   = last_s3;

endmodule
